FILE: rtl/asr_pkg.sv
// Shared types and constants of the axis sum reduction unit.
package asr_pkg;

  localparam int MaxInner = 1024;
  localparam int SlotW    = $clog2(MaxInner);
  localparam int IdxW     = 26;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;
  localparam int InnerW   = 11;

  localparam logic [63:0] DefaultNan = 64'hFFF8_0000_0000_0000;
  localparam logic [63:0] QuietBit   = 64'h0008_0000_0000_0000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_OUTER  = 2'd0,
    CFG_REDUCE = 2'd1,
    CFG_INNER  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [SlotW-1:0] slot;
    logic             wr;
    logic             emit;
    logic [IdxW-1:0]  idx;
    logic             job_last;
  } item_meta_t;

endpackage

FILE: rtl/asr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module asr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

FILE: rtl/axis_sum_reduction_unit.sv
// Top level of the axis sum reduction unit: running binary64 sums per inner position.
//
// Elements arrive in memory order (outer, reduce, inner) and one beat can be taken
// every cycle while the output is not stalled and no accumulator hazard holds it.
// Each element reads its accumulator from a 1024-entry RAM, passes a binary64
// adder (unpack, align, add, leading-zero count, normalize, round) and is written
// back, or leaves on the output when the last reduce position is reached. An
// element whose accumulator is still in the pipeline waits until the write-back
// lands; first reduce positions never wait for a write-back.
// Results leave in output order with their index and a last flag. A register
// write restarts the job at position zero; write registers only while idle.
module axis_sum_reduction_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [63:0]                   in_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [63:0]                   out_sum,
  output logic [asr_pkg::IdxW-1:0]      out_index,
  output logic                          out_job_last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [asr_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [asr_pkg::CfgDataW-1:0]  cfg_data
);

  localparam int SW = asr_pkg::SlotW;
  localparam int IW = asr_pkg::IdxW;

  // configuration and position counters
  logic [15:0]                outer_cnt_r, reduce_cnt_r;
  logic [asr_pkg::InnerW-1:0] inner_cnt_r;
  logic [SW-1:0]              inner_pos_r;
  logic [15:0]                reduce_pos_r, outer_pos_r;
  logic [IW-1:0]              base_r;

  logic [15:0]                n_outer, n_reduce;
  logic [asr_pkg::InnerW-1:0] n_inner;
  logic [SW-1:0]              slot;
  logic                       last_inner, last_reduce, last_outer, first_now;
  logic                       adv, hazard, accept, acc_we;
  asr_pkg::item_meta_t        meta_now;

  // pipeline registers
  logic                s1_v_r, e1_v_r, e2_v_r, e3_v_r, e4_v_r, e5_v_r, e6_v_r;
  asr_pkg::item_meta_t s1_meta_r, e1_meta_r, e2_meta_r, e3_meta_r, e4_meta_r, e5_meta_r;
  asr_pkg::item_meta_t e6_meta_r;
  logic                s1_first_r;
  logic [63:0]         s1_x_r;
  logic [63:0]         ram_rdata;

  logic                e1_spec_r, e2_spec_r, e3_spec_r, e4_spec_r, e5_spec_r;
  logic [63:0]         e1_sval_r, e2_sval_r, e3_sval_r, e4_sval_r, e5_sval_r;
  logic                e1_sign_r, e2_sign_r, e3_sign_r, e4_sign_r, e5_sign_r;
  logic                e1_zs_r, e2_zs_r, e3_zs_r, e4_zs_r, e5_zs_r;
  logic [10:0]         e1_exp_r, e2_exp_r, e3_exp_r, e4_exp_r;
  logic                e1_sub_r, e2_sub_r;
  logic [52:0]         e1_mb_r, e1_ms_r, e2_mb_r;
  logic [10:0]         e1_diff_r;
  logic [55:0]         e2_al_r;
  logic [56:0]         e3_sum_r, e4_sum_r;
  logic [5:0]          e4_lz_r;
  logic [55:0]         e5_m_r;
  logic [11:0]         e5_e_r;
  logic                e5_zero_r;
  logic [63:0]         e6_val_r;

  logic                out_valid_r, out_job_last_r;
  logic [63:0]         out_sum_r;
  logic [IW-1:0]       out_index_r;

  // effective sizes
  always_comb begin
    n_outer  = (outer_cnt_r == 16'd0) ? 16'd1 : outer_cnt_r;
    n_reduce = (reduce_cnt_r == 16'd0) ? 16'd1 : reduce_cnt_r;
    if (inner_cnt_r == '0) begin
      n_inner = asr_pkg::InnerW'(1);
    end else if (inner_cnt_r > asr_pkg::InnerW'(asr_pkg::MaxInner)) begin
      n_inner = asr_pkg::InnerW'(asr_pkg::MaxInner);
    end else begin
      n_inner = inner_cnt_r;
    end
  end

  always_comb begin
    if ({1'b0, inner_pos_r} >= n_inner) begin
      slot = SW'(n_inner - asr_pkg::InnerW'(1));
    end else begin
      slot = inner_pos_r;
    end
    last_inner  = ({1'b0, slot} + asr_pkg::InnerW'(1)) >= n_inner;
    last_reduce = ({1'b0, reduce_pos_r} + 17'd1) >= {1'b0, n_reduce};
    last_outer  = ({1'b0, outer_pos_r} + 17'd1) >= {1'b0, n_outer};
    first_now   = (reduce_pos_r == 16'd0);
    meta_now.slot     = slot;
    meta_now.wr       = !last_reduce;
    meta_now.emit     = last_reduce;
    meta_now.idx      = base_r + IW'(slot);
    meta_now.job_last = last_inner && last_outer;
  end

  // hold the element while an older write to its accumulator is still in flight
  always_comb begin
    hazard = !first_now && (
      (s1_v_r && s1_meta_r.wr && s1_meta_r.slot == slot) ||
      (e1_v_r && e1_meta_r.wr && e1_meta_r.slot == slot) ||
      (e2_v_r && e2_meta_r.wr && e2_meta_r.slot == slot) ||
      (e3_v_r && e3_meta_r.wr && e3_meta_r.slot == slot) ||
      (e4_v_r && e4_meta_r.wr && e4_meta_r.slot == slot) ||
      (e5_v_r && e5_meta_r.wr && e5_meta_r.slot == slot) ||
      (e6_v_r && e6_meta_r.wr && e6_meta_r.slot == slot));
  end

  assign adv       = !out_valid_r || !out_stall;
  assign in_stall  = !adv || hazard;
  assign accept    = in_valid && !in_stall;
  assign acc_we    = adv && e6_v_r && e6_meta_r.wr;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outer_cnt_r  <= 16'd1;
      reduce_cnt_r <= 16'd1;
      inner_cnt_r  <= asr_pkg::InnerW'(1);
      inner_pos_r  <= '0;
      reduce_pos_r <= '0;
      outer_pos_r  <= '0;
      base_r       <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        asr_pkg::CFG_OUTER:  outer_cnt_r  <= cfg_data;
        asr_pkg::CFG_REDUCE: reduce_cnt_r <= cfg_data;
        asr_pkg::CFG_INNER:  inner_cnt_r  <= cfg_data[asr_pkg::InnerW-1:0];
        default: ;
      endcase
      if (cfg_index == asr_pkg::CFG_OUTER || cfg_index == asr_pkg::CFG_REDUCE ||
          cfg_index == asr_pkg::CFG_INNER) begin
        inner_pos_r  <= '0;
        reduce_pos_r <= '0;
        outer_pos_r  <= '0;
        base_r       <= '0;
      end
    end else if (accept) begin
      if (!last_inner) begin
        inner_pos_r <= slot + SW'(1);
      end else begin
        inner_pos_r <= '0;
        if (!last_reduce) begin
          reduce_pos_r <= reduce_pos_r + 16'd1;
        end else begin
          reduce_pos_r <= '0;
          outer_pos_r  <= last_outer ? 16'd0 : outer_pos_r + 16'd1;
          base_r       <= last_outer ? '0 : base_r + IW'(n_inner);
        end
      end
    end
  end

  asr_ram #(.WIDTH(64), .DEPTH(asr_pkg::MaxInner)) u_acc_ram (
    .clk   (clk),
    .we    (acc_we),
    .waddr (e6_meta_r.slot),
    .wdata (e6_val_r),
    .re    (accept),
    .raddr (slot),
    .rdata (ram_rdata)
  );

  // unpack, specials, magnitude swap
  logic [63:0] op_a, op_b, big, sml, spec_val;
  logic        a_nan, b_nan, a_inf, b_inf, spec, a_ge;
  logic [10:0] eb_eff, es_eff;

  always_comb begin
    op_a  = s1_first_r ? 64'd0 : ram_rdata;
    op_b  = s1_x_r;
    a_nan = (op_a[62:52] == 11'h7FF) && (op_a[51:0] != 52'd0);
    b_nan = (op_b[62:52] == 11'h7FF) && (op_b[51:0] != 52'd0);
    a_inf = (op_a[62:52] == 11'h7FF) && (op_a[51:0] == 52'd0);
    b_inf = (op_b[62:52] == 11'h7FF) && (op_b[51:0] == 52'd0);
    spec  = 1'b1;
    if (a_nan) begin
      spec_val = op_a | asr_pkg::QuietBit;
    end else if (b_nan) begin
      spec_val = op_b | asr_pkg::QuietBit;
    end else if (a_inf && b_inf && (op_a[63] != op_b[63])) begin
      spec_val = asr_pkg::DefaultNan;
    end else if (a_inf) begin
      spec_val = op_a;
    end else if (b_inf) begin
      spec_val = op_b;
    end else begin
      spec     = 1'b0;
      spec_val = 64'd0;
    end
    a_ge   = op_a[62:0] >= op_b[62:0];
    big    = a_ge ? op_a : op_b;
    sml    = a_ge ? op_b : op_a;
    eb_eff = (big[62:52] == 11'd0) ? 11'd1 : big[62:52];
    es_eff = (sml[62:52] == 11'd0) ? 11'd1 : sml[62:52];
  end

  // align: shift the smaller operand, fold shifted-out bits into sticky
  logic [5:0]   al_sh;
  logic [119:0] al_wide;

  always_comb begin
    al_sh   = (e1_diff_r > 11'd63) ? 6'd63 : e1_diff_r[5:0];
    al_wide = {e1_ms_r, 3'b000, 64'd0} >> al_sh;
  end

  // leading zeros below the carry bit
  logic [5:0] lz;

  always_comb begin
    lz = 6'd56;
    for (int i = 0; i < 56; i++) begin
      if (e3_sum_r[i]) begin
        lz = 6'(55 - i);
      end
    end
  end

  // normalize
  logic [10:0] nrm_cap;
  logic [5:0]  nrm_sh;

  always_comb begin
    nrm_cap = e4_exp_r - 11'd1;
    nrm_sh  = ({5'd0, e4_lz_r} > nrm_cap) ? nrm_cap[5:0] : e4_lz_r;
  end

  // round to nearest even and pack
  logic        rnd_up;
  logic [53:0] rnd_m;
  logic [11:0] rnd_e;
  logic [63:0] rnd_val;

  always_comb begin
    rnd_up = e5_m_r[2] && (e5_m_r[1] || e5_m_r[0] || e5_m_r[3]);
    rnd_m  = {1'b0, e5_m_r[55:3]} + {53'd0, rnd_up};
    if (rnd_m[53]) begin
      rnd_e = e5_e_r + 12'd1;
    end else if (rnd_m[52]) begin
      rnd_e = e5_e_r;
    end else begin
      rnd_e = 12'd0;
    end
    if (e5_spec_r) begin
      rnd_val = e5_sval_r;
    end else if (e5_zero_r) begin
      rnd_val = {e5_zs_r, 63'd0};
    end else if (rnd_e >= 12'd2047) begin
      rnd_val = {e5_sign_r, 11'h7FF, 52'd0};
    end else begin
      rnd_val = {e5_sign_r, rnd_e[10:0], rnd_m[53] ? 52'd0 : rnd_m[51:0]};
    end
  end

  // pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      e1_v_r      <= 1'b0;
      e2_v_r      <= 1'b0;
      e3_v_r      <= 1'b0;
      e4_v_r      <= 1'b0;
      e5_v_r      <= 1'b0;
      e6_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_v_r      <= accept;
      e1_v_r      <= s1_v_r;
      e2_v_r      <= e1_v_r;
      e3_v_r      <= e2_v_r;
      e4_v_r      <= e3_v_r;
      e5_v_r      <= e4_v_r;
      e6_v_r      <= e5_v_r;
      out_valid_r <= e6_v_r && e6_meta_r.emit;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_meta_r  <= meta_now;
      s1_first_r <= first_now;
      s1_x_r     <= in_value;

      e1_meta_r <= s1_meta_r;
      e1_spec_r <= spec;
      e1_sval_r <= spec_val;
      e1_sign_r <= big[63];
      e1_zs_r   <= op_a[63] && op_b[63];
      e1_sub_r  <= op_a[63] != op_b[63];
      e1_exp_r  <= eb_eff;
      e1_mb_r   <= {big[62:52] != 11'd0, big[51:0]};
      e1_ms_r   <= {sml[62:52] != 11'd0, sml[51:0]};
      e1_diff_r <= eb_eff - es_eff;

      e2_meta_r <= e1_meta_r;
      e2_spec_r <= e1_spec_r;
      e2_sval_r <= e1_sval_r;
      e2_sign_r <= e1_sign_r;
      e2_zs_r   <= e1_zs_r;
      e2_sub_r  <= e1_sub_r;
      e2_exp_r  <= e1_exp_r;
      e2_mb_r   <= e1_mb_r;
      e2_al_r   <= {al_wide[119:65], al_wide[64] | (|al_wide[63:0])};

      e3_meta_r <= e2_meta_r;
      e3_spec_r <= e2_spec_r;
      e3_sval_r <= e2_sval_r;
      e3_sign_r <= e2_sign_r;
      e3_zs_r   <= e2_zs_r;
      e3_exp_r  <= e2_exp_r;
      e3_sum_r  <= e2_sub_r ? ({1'b0, e2_mb_r, 3'b000} - {1'b0, e2_al_r})
                            : ({1'b0, e2_mb_r, 3'b000} + {1'b0, e2_al_r});

      e4_meta_r <= e3_meta_r;
      e4_spec_r <= e3_spec_r;
      e4_sval_r <= e3_sval_r;
      e4_sign_r <= e3_sign_r;
      e4_zs_r   <= e3_zs_r;
      e4_exp_r  <= e3_exp_r;
      e4_sum_r  <= e3_sum_r;
      e4_lz_r   <= lz;

      e5_meta_r <= e4_meta_r;
      e5_spec_r <= e4_spec_r;
      e5_sval_r <= e4_sval_r;
      e5_sign_r <= e4_sign_r;
      e5_zs_r   <= e4_zs_r;
      e5_zero_r <= (e4_sum_r == 57'd0);
      if (e4_sum_r[56]) begin
        e5_m_r <= {e4_sum_r[56:2], e4_sum_r[1] | e4_sum_r[0]};
        e5_e_r <= {1'b0, e4_exp_r} + 12'd1;
      end else begin
        e5_m_r <= e4_sum_r[55:0] << nrm_sh;
        e5_e_r <= {1'b0, e4_exp_r} - {6'd0, nrm_sh};
      end

      e6_meta_r <= e5_meta_r;
      e6_val_r  <= rnd_val;

      if (e6_v_r && e6_meta_r.emit) begin
        out_sum_r      <= e6_val_r;
        out_index_r    <= e6_meta_r.idx;
        out_job_last_r <= e6_meta_r.job_last;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_sum      = out_sum_r;
  assign out_index    = out_index_r;
  assign out_job_last = out_job_last_r;

  // a reading element never has an older write to its slot ahead of it
  a_no_raw: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !s1_first_r) |->
      !((e1_v_r && e1_meta_r.wr && e1_meta_r.slot == s1_meta_r.slot) ||
        (e2_v_r && e2_meta_r.wr && e2_meta_r.slot == s1_meta_r.slot) ||
        (e3_v_r && e3_meta_r.wr && e3_meta_r.slot == s1_meta_r.slot) ||
        (e4_v_r && e4_meta_r.wr && e4_meta_r.slot == s1_meta_r.slot) ||
        (e5_v_r && e5_meta_r.wr && e5_meta_r.slot == s1_meta_r.slot) ||
        (e6_v_r && e6_meta_r.wr && e6_meta_r.slot == s1_meta_r.slot)))
    else $error("accumulator read overtakes pending write");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && !adv) |=> ($stable(e6_v_r) && $stable(e6_val_r) && $stable(s1_v_r)))
    else $error("pipeline moved while output held");

  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && (cfg_index == asr_pkg::CFG_OUTER || cfg_index == asr_pkg::CFG_REDUCE ||
                   cfg_index == asr_pkg::CFG_INNER))
      |=> (inner_pos_r == '0 && reduce_pos_r == 16'd0 && outer_pos_r == 16'd0))
    else $error("register write did not restart the job");

endmodule

FILE: verif/axis_sum_reduction_checker.sv
// Scoreboard for the axis sum reduction unit: tracks the job, predicts each sum, compares.
module axis_sum_reduction_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [63:0]                  in_value,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [63:0]                  out_sum,
  input  logic [asr_pkg::IdxW-1:0]     out_index,
  input  logic                         out_job_last,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [asr_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [asr_pkg::CfgDataW-1:0] cfg_data,
  output int                           errors,
  output int                           pending,
  output int                           sums_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [63:0]              sum;
    logic [asr_pkg::IdxW-1:0] index;
    logic                     job_last;
  } sum_beat_t;

  sum_beat_t   sums_due[$];
  logic [15:0] outer_reg, reduce_reg;
  logic [10:0] inner_reg;
  logic [63:0] partial_sums [asr_pkg::MaxInner];
  int unsigned col, row, blk;

  initial begin
    errors = 0;
    pending = 0;
    sums_checked = 0;
  end

  task automatic report(string what);
    $display("checker: mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  // Fold one element into its running sum; queue the finished sum on the last row.
  task automatic fold_element(logic [63:0] value);
    int unsigned n_outer, n_reduce, n_inner, slot;
    real acc;
    logic [63:0] pos;
    sum_beat_t b;
    n_outer  = (outer_reg == 16'd0) ? 1 : 32'(outer_reg);
    n_reduce = (reduce_reg == 16'd0) ? 1 : 32'(reduce_reg);
    n_inner  = (inner_reg == 11'd0) ? 1 :
               ((32'(inner_reg) > asr_pkg::MaxInner) ? asr_pkg::MaxInner : 32'(inner_reg));
    slot = (col >= n_inner) ? n_inner - 1 : col;
    if (row == 0) acc = 0.0 + $bitstoreal(value);
    else acc = $bitstoreal(partial_sums[slot]) + $bitstoreal(value);
    if (row + 1 >= n_reduce) begin
      pos = 64'(blk) * 64'(n_inner) + 64'(slot);
      b.sum = $realtobits(acc);
      b.index = pos[asr_pkg::IdxW-1:0];
      b.job_last = (slot + 1 >= n_inner) && (blk + 1 >= n_outer);
      sums_due.push_back(b);
    end else begin
      partial_sums[slot] = $realtobits(acc);
    end
    if (slot + 1 < n_inner) begin
      col = slot + 1;
    end else begin
      col = 0;
      if (row + 1 < n_reduce) begin
        row++;
      end else begin
        row = 0;
        blk = (blk + 1 >= n_outer) ? 0 : blk + 1;
      end
    end
  endtask

  always @(posedge clk) begin
    sum_beat_t b;
    if (!rst_n) begin
      outer_reg = 16'd1;
      reduce_reg = 16'd1;
      inner_reg = 11'd1;
      col = 0;
      row = 0;
      blk = 0;
      sums_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          asr_pkg::CFG_OUTER:  outer_reg = cfg_data;
          asr_pkg::CFG_REDUCE: reduce_reg = cfg_data;
          asr_pkg::CFG_INNER:  inner_reg = cfg_data[10:0];
          default: ;
        endcase
        // any write to a real register restarts the job
        if (cfg_index inside {asr_pkg::CFG_OUTER, asr_pkg::CFG_REDUCE,
                              asr_pkg::CFG_INNER}) begin
          col = 0;
          row = 0;
          blk = 0;
        end
      end
      if (in_valid && !in_stall) fold_element(in_value);
      if (out_valid && !out_stall) begin
        if (sums_due.size() == 0) begin
          report($sformatf("unexpected sum %h index %0d", out_sum, out_index));
        end else begin
          b = sums_due.pop_front();
          sums_checked <= sums_checked + 1;
          if (out_sum !== b.sum)
            report($sformatf("sum %h, want %h (index %0d)", out_sum, b.sum, b.index));
          if (out_index !== b.index)
            report($sformatf("index %0d, want %0d", out_index, b.index));
          if (out_job_last !== b.job_last)
            report($sformatf("job_last %b, want %b (index %0d)",
                             out_job_last, b.job_last, b.index));
        end
      end
    end
    pending <= sums_due.size();
  end

endmodule

FILE: verif/tb.sv
// Testbench top for the axis sum reduction unit: stimulus, stalls and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [asr_pkg::CfgIdxW-1:0] CfgUnused = 2'd3;
  localparam int Settle = 40;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [63:0]                  in_value = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [63:0]                  out_sum;
  logic [asr_pkg::IdxW-1:0]     out_index;
  logic                         out_job_last;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [asr_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [asr_pkg::CfgDataW-1:0] cfg_data = '0;

  int   errors, pending, sums_checked;
  int   sent = 0;
  int   settings = 0;
  logic calm = 1'b0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;

  always #1 clk = ~clk;

  axis_sum_reduction_unit dut (.*);

  axis_sum_reduction_checker chk (.*);

  // Receiver: random stalls, plus one long hold-off once requested.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= 400;
      hold_done <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 8);
    end
  end

  task automatic push(logic [63:0] v);
    while (!calm && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  // Drop valid, then wait until every sum is out and the pipeline has emptied.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (Settle) @(posedge clk);
  endtask

  // Leaves valid high so writes can follow back to back; the caller drops it.
  task automatic write_reg(logic [asr_pkg::CfgIdxW-1:0] idx,
                           logic [asr_pkg::CfgDataW-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_sizes(logic [15:0] o, logic [15:0] r, logic [15:0] i);
    write_reg(asr_pkg::CFG_OUTER, o);
    write_reg(asr_pkg::CFG_REDUCE, r);
    write_reg(asr_pkg::CFG_INNER, i);
    cfg_valid <= 1'b0;
    settings++;
  endtask

  function automatic logic [63:0] rand_element();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(4))
          0: return {raw[63], 63'h0};
          1: return {raw[63], 11'h7FF, 52'h0};
          2: return {raw[63], 11'h7FF, raw[51:0] | 52'h1};
          3: return {raw[63], 11'h0, raw[51:0]};
          default: return {raw[63], 11'h7FE, raw[51:0]};
        endcase
      end
      1, 2: return raw;
      // moderate magnitudes so the sums cancel, round and carry
      default: return {raw[63], 11'(1003 + $urandom_range(40)), raw[51:0]};
    endcase
  endfunction

  initial begin
    int n_o, n_r, n_i;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset sizes: every element is its own sum
    push(64'h0000_0000_0000_0000);
    push(64'h8000_0000_0000_0000);
    push(64'h7FF0_0000_0000_0000);
    push(64'hFFF0_0000_0000_0000);
    push(64'h7FF8_0000_0000_0000);
    push(64'h7FF0_0000_0000_0001);
    push(64'h7FEF_FFFF_FFFF_FFFF);
    push(64'h0000_0000_0000_0001);
    push(64'hFFFF_FFFF_FFFF_FFFF);
    drain();

    // pairs: opposite infinities, exact cancel, overflow, subnormal carry, tie to even, negative zeros
    set_sizes(16'd1, 16'd2, 16'd1);
    push(64'h7FF0_0000_0000_0000); push(64'hFFF0_0000_0000_0000);
    push(64'h3FF0_0000_0000_0000); push(64'hBFF0_0000_0000_0000);
    push(64'h7FEF_FFFF_FFFF_FFFF); push(64'h7FEF_FFFF_FFFF_FFFF);
    push(64'h000F_FFFF_FFFF_FFFF); push(64'h0000_0000_0000_0001);
    push(64'h3FF0_0000_0000_0000); push(64'h3CA0_0000_0000_0000);
    push(64'h8000_0000_0000_0000); push(64'h8000_0000_0000_0000);
    drain();

    // a write past the register list changes nothing
    write_reg(CfgUnused, 16'hFFFF);
    cfg_valid <= 1'b0;
    push(64'h4000_0000_0000_0000); push(64'h4008_0000_0000_0000);
    drain();

    // zero sizes act as one
    set_sizes(16'd0, 16'd0, 16'd0);
    push(64'h4010_0000_0000_0000); push(64'hC010_0000_0000_0000);
    drain();

    // largest sizes: partial job, then cut short by the next write
    set_sizes(16'hFFFF, 16'hFFFF, 16'd1024);
    repeat (20) push(rand_element());
    drain();
    set_sizes(16'hFFFF, 16'd1, 16'd1);
    repeat (20) push(rand_element());
    drain();

    // inner above the store depth acts as the depth; no idling, hold the output to back up
    set_sizes(16'd1, 16'd1, 16'd2047);
    calm <= 1'b1;
    hold_req <= 1'b1;
    repeat (1024) push(rand_element());
    drain();
    calm <= 1'b0;

    while (sent < 1200) begin
      n_o = $urandom_range(1, 3);
      n_r = $urandom_range(1, 8);
      n_i = ($urandom_range(3) == 0) ? $urandom_range(1, 2) : $urandom_range(1, 16);
      set_sizes(16'(n_o), 16'(n_r), 16'(n_i));
      calm <= ($urandom_range(5) == 0);
      // sometimes run one job and a bit more, leaving the second unfinished
      repeat (n_o * n_r * n_i + (($urandom_range(3) == 0) ? $urandom_range(1, 9) : 0))
        push(rand_element());
      drain();
    end
    calm <= 1'b0;

    $display("tb: %0d elements over %0d size settings, %0d sums compared",
             sent, settings, sums_checked);
    $display("tb: covered specials, rounding ties, oversize and zero sizes, long output hold");
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin
    #1ms;
    $display("tb: timeout");
    $display("tb: done, errors");
    $finish;
  end

endmodule
